### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define U2U_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u2u check failed: same-cycle implication");

// Check that a condition implies another on the following cycle.
`define U2U_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u2u check failed: next-cycle implication");

`endif

### hdl/u2u_pkg.sv
`default_nettype none

package u2u_pkg;

   // Result kinds
   localparam logic [1:0] KIND_UNIT = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Decoder phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SEQ  = 2'd1;
   localparam logic [1:0] PH_DROP = 2'd2;

   // Byte class boundaries and payload masks
   localparam logic [7:0] BYTE_CONT   = 8'h80;
   localparam logic [7:0] BYTE_LEAD2  = 8'hC0;
   localparam logic [7:0] BYTE_LEAD3  = 8'hE0;
   localparam logic [7:0] BYTE_LEAD4  = 8'hF0;
   localparam logic [7:0] MASK_LEAD2  = 8'h1F;
   localparam logic [7:0] MASK_LEAD3  = 8'h0F;
   localparam logic [7:0] MASK_CONT   = 8'h3F;

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] code_unit;
      logic [15:0] unit_count;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/u2u_decode.sv
`default_nettype none

module u2u_decode (
   input  wire              clock,
   input  wire              reset,
   input  wire              advance,
   input  wire [7:0]        byte_in,
   input  wire [15:0]       capacity,
   output logic             has_result,
   output u2u_pkg::rsp_type result
);

   logic [1:0]  phase_ff,   phase_in;
   logic        need_ff,    need_in;
   logic [15:0] partial_ff, partial_in;
   logic [15:0] count_ff,   count_in;

   logic [15:0] lead2_bits;
   logic [15:0] lead3_bits;
   logic [15:0] mid_bits;
   logic [15:0] last_bits;
   logic        is_cont;

   // Payload bits of each byte position
   assign lead2_bits = {5'd0, byte_in[4:0] & u2u_pkg::MASK_LEAD2[4:0], 6'd0};
   assign lead3_bits = {byte_in[3:0] & u2u_pkg::MASK_LEAD3[3:0], 12'd0};
   assign mid_bits   = {4'd0, byte_in[5:0] & u2u_pkg::MASK_CONT[5:0], 6'd0};
   assign last_bits  = {10'd0, byte_in[5:0] & u2u_pkg::MASK_CONT[5:0]};
   assign is_cont    = (byte_in >= u2u_pkg::BYTE_CONT) && (byte_in < u2u_pkg::BYTE_LEAD2);

   // Decode one byte against the current phase
   always_comb begin
      phase_in   = phase_ff;
      need_in    = need_ff;
      partial_in = partial_ff;
      count_in   = count_ff;
      has_result = 1'b0;
      result     = '0;
      unique case (phase_ff)
         u2u_pkg::PH_IDLE: begin
            priority if (byte_in == 8'd0) begin
               has_result        = 1'b1;
               result.kind       = u2u_pkg::KIND_END;
               result.unit_count = count_ff;
               phase_in          = u2u_pkg::PH_IDLE;
               need_in           = 1'b0;
               partial_in        = '0;
               count_in          = '0;
            end else if (count_ff >= capacity) begin
               has_result  = 1'b1;
               result.kind = u2u_pkg::KIND_ERR;
               phase_in    = u2u_pkg::PH_DROP;
               need_in     = 1'b0;
               partial_in  = '0;
            end else if (byte_in < u2u_pkg::BYTE_CONT) begin
               has_result       = 1'b1;
               result.kind      = u2u_pkg::KIND_UNIT;
               result.code_unit = {8'd0, byte_in};
               count_in         = count_ff + 16'd1;
            end else if (byte_in < u2u_pkg::BYTE_LEAD2) begin
               has_result  = 1'b1;
               result.kind = u2u_pkg::KIND_ERR;
               phase_in    = u2u_pkg::PH_DROP;
               need_in     = 1'b0;
               partial_in  = '0;
            end else if (byte_in < u2u_pkg::BYTE_LEAD3) begin
               partial_in = lead2_bits;
               need_in    = 1'b0;
               phase_in   = u2u_pkg::PH_SEQ;
            end else if (byte_in < u2u_pkg::BYTE_LEAD4) begin
               partial_in = lead3_bits;
               need_in    = 1'b1;
               phase_in   = u2u_pkg::PH_SEQ;
            end else begin
               has_result  = 1'b1;
               result.kind = u2u_pkg::KIND_ERR;
               phase_in    = u2u_pkg::PH_DROP;
               need_in     = 1'b0;
               partial_in  = '0;
            end
         end
         u2u_pkg::PH_SEQ: begin
            priority if (byte_in == 8'd0) begin
               // zero ends the string at once: error, no drop phase
               has_result  = 1'b1;
               result.kind = u2u_pkg::KIND_ERR;
               phase_in    = u2u_pkg::PH_IDLE;
               need_in     = 1'b0;
               partial_in  = '0;
               count_in    = '0;
            end else if (!is_cont) begin
               has_result  = 1'b1;
               result.kind = u2u_pkg::KIND_ERR;
               phase_in    = u2u_pkg::PH_DROP;
               need_in     = 1'b0;
               partial_in  = '0;
            end else if (need_ff) begin
               partial_in = partial_ff | mid_bits;
               need_in    = 1'b0;
            end else begin
               has_result       = 1'b1;
               result.kind      = u2u_pkg::KIND_UNIT;
               result.code_unit = partial_ff | last_bits;
               partial_in       = '0;
               phase_in         = u2u_pkg::PH_IDLE;
               count_in         = count_ff + 16'd1;
            end
         end
         default: begin
            // drop silently until a zero byte clears the string
            if (byte_in == 8'd0) begin
               phase_in   = u2u_pkg::PH_IDLE;
               need_in    = 1'b0;
               partial_in = '0;
               count_in   = '0;
            end
         end
      endcase
   end

   // Advance decoder state once per consumed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= u2u_pkg::PH_IDLE;
         need_ff    <= 1'b0;
         partial_ff <= '0;
         count_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         need_ff    <= need_in;
         partial_ff <= partial_in;
         count_ff   <= count_in;
      end
   end

endmodule

`default_nettype wire

### hdl/u2u_rsp_buf.sv
`default_nettype none

module u2u_rsp_buf (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire u2u_pkg::rsp_type push_data,
   output logic                  room,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output u2u_pkg::rsp_type      head
);

   logic [1:0]       count_ff, count_in;
   logic [1:0]       count_left;
   logic             pop;
   u2u_pkg::rsp_type slot0_ff, slot0_in;
   u2u_pkg::rsp_type slot1_ff, slot1_in;

   assign rsp_valid  = (count_ff != 2'd0);
   assign head       = slot0_ff;
   assign pop        = rsp_valid && !rsp_stall;
   assign count_left = count_ff - {1'b0, pop};
   assign room       = (count_ff != 2'd2) || pop;

   // Shift on pop, write behind the remaining words
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (count_left == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
      count_in = count_left + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

### hdl/utf8_to_ucs2_decoder.sv
// UTF-8 to 16-bit code unit decoder, 1- to 3-byte forms.
// Request channel: req_valid / req_stall carry one UTF-8 byte per word on
// req_byte_in; a zero byte ends the string.
// Response channel: rsp_valid / rsp_stall carry rsp_kind (code unit, end of
// string, error), rsp_code_unit and rsp_unit_count. A byte yields zero or one
// response word.
// Config channel: csr_valid / csr_ready write csr_capacity_units, the most
// units per string; csr_ready is always high. Write it only while idle.
// Path: a taken byte waits in the byte register for the decode stage, and its
// response word goes into the response buffer, whose head drives the ports.
// Throughput: one byte per cycle, set by the single decode stage between the
// byte register and a two-word response buffer, except when a full buffer stalls a byte.
// Reset clears the decoder to await a lead byte, empties the response buffer
// and sets the capacity to 65535.
// When rsp_stall holds, the buffer fills after two words and then req_stall
// rises for the bytes that would produce a response.
`default_nettype none

module utf8_to_ucs2_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_code_unit,
   output logic [15:0] rsp_unit_count,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_capacity_units
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       byte_ff;
   logic [15:0]      capacity_ff;
   logic             req_take;
   logic             advance;
   logic             has_result;
   logic             room;
   u2u_pkg::rsp_type result;
   u2u_pkg::rsp_type head;

   assign csr_ready   = 1'b1;
   assign advance     = in_valid_ff && (!has_result || room);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= u2u_pkg::CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_capacity_units;
      end
   end

   // Byte register in front of the decode stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_byte_in;
      end
   end

   u2u_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_in    (byte_ff),
      .capacity   (capacity_ff),
      .has_result (has_result),
      .result     (result)
   );

   u2u_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && has_result),
      .push_data (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind       = head.kind;
   assign rsp_code_unit  = head.code_unit;
   assign rsp_unit_count = head.unit_count;

endmodule

`default_nettype wire

### hdl/u2u_checker.sv
`default_nettype none
`include "assert_macros.svh"

module u2u_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [1:0]  rsp_kind,
   input wire [15:0] rsp_code_unit,
   input wire [15:0] rsp_unit_count
);

   logic        rsp_held;
   logic [33:0] rsp_word;
   logic        kind_ok;
   logic        not_unit;
   logic        not_end;

   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_word = {rsp_kind, rsp_code_unit, rsp_unit_count};
   assign kind_ok  = (rsp_kind == u2u_pkg::KIND_UNIT) || (rsp_kind == u2u_pkg::KIND_END) ||
                     (rsp_kind == u2u_pkg::KIND_ERR);
   assign not_unit = rsp_valid && (rsp_kind != u2u_pkg::KIND_UNIT);
   assign not_end  = rsp_valid && (rsp_kind != u2u_pkg::KIND_END);

   // Hold a stalled response word
   `U2U_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))

   // Only the three defined kinds appear
   `U2U_ASSERT_SAME(a_kind_legal, clock, reset, rsp_valid, kind_ok)

   // Code unit is zero unless a unit is reported
   `U2U_ASSERT_SAME(a_unit_zero, clock, reset, not_unit, rsp_code_unit == 16'd0)

   // Count is zero unless the string ends
   `U2U_ASSERT_SAME(a_count_zero, clock, reset, not_end, rsp_unit_count == 16'd0)

endmodule

bind utf8_to_ucs2_decoder u2u_checker u_checker (.*);

`default_nettype wire

### sim/utf8_to_ucs2_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_tb;

   localparam int unsigned IDLE_PCT         = 29;
   localparam int unsigned ITEMS_PER_PHASE  = 190;
   localparam int unsigned HOLD_CYCLES      = 300;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned MAX_PRINTED      = 100;

   // Track the decoder state and the words it still owes
   class decode_tracker;
      logic [15:0]      capacity;
      logic [1:0]       phase;
      bit               need_two_more;
      logic [15:0]      partial_value;
      logic [15:0]      emitted;
      u2u_pkg::rsp_type due_words[$];
      int unsigned      error_count;

      function new();
         capacity = u2u_pkg::CAPACITY_RESET;
         error_count = 0;
         clear_string();
      endfunction

      function void clear_string();
         phase = u2u_pkg::PH_IDLE;
         need_two_more = 1'b0;
         partial_value = '0;
         emitted = '0;
      endfunction

      function void set_capacity(logic [15:0] value);
         capacity = value;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      // Enter the drop phase and owe an error word
      function u2u_pkg::rsp_type drop_word();
         u2u_pkg::rsp_type w;
         w = '0;
         w.kind = u2u_pkg::KIND_ERR;
         phase = u2u_pkg::PH_DROP;
         need_two_more = 1'b0;
         partial_value = '0;
         return w;
      endfunction

      // Decode one accepted byte and queue the word it causes, if any
      function void note_byte(logic [7:0] b);
         u2u_pkg::rsp_type w;
         bit               owed;
         w = '0;
         owed = 1'b1;
         case (phase)
            u2u_pkg::PH_IDLE: begin
               if (b == 8'h00) begin
                  w.kind = u2u_pkg::KIND_END;
                  w.unit_count = emitted;
                  clear_string();
               end else if (emitted >= capacity) begin
                  w = drop_word();
               end else if (b < u2u_pkg::BYTE_CONT) begin
                  emitted = emitted + 16'd1;
                  w.kind = u2u_pkg::KIND_UNIT;
                  w.code_unit = {8'h00, b};
               end else if (b < u2u_pkg::BYTE_LEAD2) begin
                  w = drop_word();
               end else if (b < u2u_pkg::BYTE_LEAD3) begin
                  partial_value = {8'h00, b & u2u_pkg::MASK_LEAD2} << 6;
                  need_two_more = 1'b0;
                  phase = u2u_pkg::PH_SEQ;
                  owed = 1'b0;
               end else if (b < u2u_pkg::BYTE_LEAD4) begin
                  partial_value = {8'h00, b & u2u_pkg::MASK_LEAD3} << 12;
                  need_two_more = 1'b1;
                  phase = u2u_pkg::PH_SEQ;
                  owed = 1'b0;
               end else begin
                  w = drop_word();
               end
            end
            u2u_pkg::PH_SEQ: begin
               if (b == 8'h00) begin
                  // zero inside a sequence ends the string at once
                  clear_string();
                  w.kind = u2u_pkg::KIND_ERR;
               end else if (b < u2u_pkg::BYTE_CONT || b >= u2u_pkg::BYTE_LEAD2) begin
                  w = drop_word();
               end else if (need_two_more) begin
                  partial_value = partial_value | ({8'h00, b & u2u_pkg::MASK_CONT} << 6);
                  need_two_more = 1'b0;
                  owed = 1'b0;
               end else begin
                  w.kind = u2u_pkg::KIND_UNIT;
                  w.code_unit = partial_value | {8'h00, b & u2u_pkg::MASK_CONT};
                  partial_value = '0;
                  phase = u2u_pkg::PH_IDLE;
                  emitted = emitted + 16'd1;
               end
            end
            default: begin
               // drop until the next zero byte, which clears the string
               if (b == 8'h00)
                  clear_string();
               owed = 1'b0;
            end
         endcase
         if (owed)
            due_words.push_back(w);
      endfunction

      // Print one line per mismatch, keep counting once the print cap is hit
      task report(string text);
         error_count++;
         if (error_count <= MAX_PRINTED)
            $display("%0t: mismatch: %s", $time, text);
      endtask

      // Compare a received word with the oldest word owed
      task check_word(u2u_pkg::rsp_type got);
         u2u_pkg::rsp_type want;
         if (due_words.size() == 0) begin
            report($sformatf("word with no byte owing it: kind %0d unit %h count %0d",
                             got.kind, got.code_unit, got.unit_count));
         end else begin
            want = due_words.pop_front();
            if (got.kind !== want.kind)
               report($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.code_unit !== want.code_unit)
               report($sformatf("code_unit got %h want %h", got.code_unit, want.code_unit));
            if (got.unit_count !== want.unit_count)
               report($sformatf("unit_count got %0d want %0d",
                                got.unit_count, want.unit_count));
         end
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_code_unit;
   logic [15:0] rsp_unit_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_capacity_units = 16'h0000;

   decode_tracker tracker = new;
   logic [7:0]    byte_q[$];
   bit            idle_on = 1'b1;
   bit            hold_pending = 1'b0;

   utf8_to_ucs2_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_code_unit      (rsp_code_unit),
      .rsp_unit_count     (rsp_unit_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_units (csr_capacity_units)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one byte, with random gaps ahead of it, and hold it until taken
   task automatic send_byte(input logic [7:0] value);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      tracker.note_byte(value);
   endtask

   task automatic send_queue();
      foreach (byte_q[i])
         send_byte(byte_q[i]);
   endtask

   task automatic push_cont();
      logic [7:0] tail;
      tail = 8'($urandom_range(63));
      byte_q.push_back(u2u_pkg::BYTE_CONT | tail);
   endtask

   // Append one well-formed character of one, two or three bytes
   task automatic add_char();
      logic [7:0] pick;
      case ($urandom_range(2))
         0: begin
            pick = 8'($urandom_range(1, 127));
            byte_q.push_back(pick);
         end
         1: begin
            pick = 8'($urandom_range(31));
            byte_q.push_back(u2u_pkg::BYTE_LEAD2 | pick);
            push_cont();
         end
         default: begin
            pick = 8'($urandom_range(15));
            byte_q.push_back(u2u_pkg::BYTE_LEAD3 | pick);
            push_cont();
            push_cont();
         end
      endcase
   endtask

   // Append a broken sequence or random bytes, then up to three random nonzero bytes
   task automatic add_break();
      logic [7:0]  pick;
      int unsigned junk;
      case ($urandom_range(4))
         0: begin
            // stray continuation
            pick = 8'($urandom_range(63));
            byte_q.push_back(u2u_pkg::BYTE_CONT | pick);
         end
         1: begin
            // four-byte or longer lead
            pick = 8'($urandom_range(15));
            byte_q.push_back(u2u_pkg::BYTE_LEAD4 | pick);
         end
         2: begin
            // lead, then a byte that is not a continuation
            pick = 8'($urandom_range(47));
            byte_q.push_back(u2u_pkg::BYTE_LEAD2 | pick);
            if (pick >= 8'd32 && $urandom_range(1) == 1)
               push_cont();
            if ($urandom_range(1) == 1)
               pick = 8'($urandom_range(1, 127));
            else
               pick = 8'($urandom_range(192, 255));
            byte_q.push_back(pick);
         end
         3: begin
            // sequence cut short by the terminator
            pick = 8'($urandom_range(47));
            byte_q.push_back(u2u_pkg::BYTE_LEAD2 | pick);
            if (pick >= 8'd32 && $urandom_range(1) == 1)
               push_cont();
            byte_q.push_back(8'h00);
         end
         default: begin
            junk = $urandom_range(1, 4);
            repeat (junk) begin
               pick = 8'($urandom_range(255));
               byte_q.push_back(pick);
            end
         end
      endcase
      junk = $urandom_range(3);
      repeat (junk) begin
         pick = 8'($urandom_range(1, 255));
         byte_q.push_back(pick);
      end
   endtask

   // Build one zero-terminated string, broken in about a quarter of cases
   task automatic compose_string();
      int unsigned chars;
      int unsigned break_at;
      int unsigned i;
      byte_q.delete();
      chars = $urandom_range(8);
      break_at = ($urandom_range(99) < 25) ? $urandom_range(chars) : chars + 1;
      for (i = 0; i <= chars; i++) begin
         if (i == break_at)
            add_break();
         if (i < chars)
            add_char();
      end
      byte_q.push_back(8'h00);
   endtask

   task automatic send_random(input int unsigned count);
      int unsigned sent;
      sent = 0;
      while (sent < count) begin
         compose_string();
         send_queue();
         sent += byte_q.size();
      end
   endtask

   // Stop offering, wait for every owed word, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_capacity_units <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      tracker.set_capacity(value);
      csr_valid <= 1'b0;
   endtask

   // Receive words and drive the result-side stall
   initial begin
      u2u_pkg::rsp_type got;
      int unsigned      hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.kind = rsp_kind;
            got.code_unit = rsp_code_unit;
            got.unit_count = rsp_unit_count;
            tracker.check_word(got);
         end
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // End the run when no word moves on any channel for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("utf8_to_ucs2_decoder_tb: done, errors");
      $finish;
   end

   initial begin
      int unsigned step;
      logic [15:0] cap;
      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      // Directed bytes at the reset capacity: empty string, ASCII and
      // multi-byte extremes with overlong forms, then each malformed-sequence error
      byte_q = {8'h00,
                8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
                8'hEF, 8'hBF, 8'hBF, 8'h00,
                8'h80, 8'h55, 8'h00,
                8'hF0, 8'h00,
                8'hC3, 8'h41, 8'h00,
                8'hE1, 8'h80, 8'h00};
      send_queue();
      send_random(ITEMS_PER_PHASE);

      for (step = 1; step <= 6; step++) begin
         drain();
         case (step)
            1:       cap = 16'd0;
            2:       cap = 16'd1;
            3:       cap = 16'd3;
            4:       cap = 16'($urandom_range(2, 12));
            5:       cap = 16'($urandom_range(16'hFFFF));
            default: cap = 16'hFFFF;
         endcase
         idle_on = (step != 4);
         write_capacity(cap);
         // Hold results off while bytes keep coming, so the input backs up
         if (step == 3)
            hold_pending = 1'b1;
         send_random(ITEMS_PER_PHASE);
      end

      drain();
      if (tracker.error_count == 0 && tracker.pending() == 0)
         $display("utf8_to_ucs2_decoder_tb: done, clean");
      else
         $display("utf8_to_ucs2_decoder_tb: done, errors");
      $finish;
   end

endmodule
